// ===== sv/sine_cosine_series_unit_macros.svh =====
// Assertion macros for the sine and cosine series unit.
// Depends on nothing; included by the top level only.
`ifndef SINE_COSINE_SERIES_UNIT_MACROS_SVH
`define SINE_COSINE_SERIES_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCSU_CHECK(lbl, ck, rn, pre, post, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCSU_CHECK_NEXT(lbl, ck, rn, pre, post, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/scsu_pkg.sv =====
// Shared types and constants of the sine and cosine series unit.
// Depends on nothing; used by scsu_term, scsu_queue, scsu_front, scsu_back and the top level.
`timescale 1ns / 1ps

package scsu_pkg;
	localparam int SERIES_TERMS_DEF = 12;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int FRAC = 58;
	localparam int DIV_W = 12;
	localparam int K_W = 14;
	localparam int K_SHIFT = 50;
	localparam logic [31:0] TWO_OVER_PI_Q32 = 32'hA2F9836E;
	localparam logic [46:0] TWO_PI_Q44 = 47'h6487ED5110B4;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
	localparam logic [63:0] ONE_Q58 = 64'd1 << FRAC;
	localparam logic [63:0] K_ROUND = 64'd1 << (K_SHIFT - 1);
	localparam logic [63:0] OUT_ROUND = 64'd1 << (FRAC - 31);

	typedef logic [63:0] q58_t;

	typedef struct packed {
		q58_t mag;
		logic neg;
	} qitem_t;

	typedef struct packed {
		logic vld;
		logic tneg;
		q58_t m2;
		q58_t acc;
	} lane_t;
endpackage

// ===== sv/scsu_if.sv =====
// Handshake channels of the sine and cosine series unit.
// Depends on nothing; one interface for the angle word, one for the result word.
`timescale 1ns / 1ps

interface scsu_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] angle;
	modport source (output valid, output angle, input ready);
	modport sink (input valid, input angle, output ready);
endinterface

interface scsu_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] sine;
	logic signed [31:0] cosine;
	modport source (output valid, output sine, output cosine, input ready);
	modport sink (input valid, input sine, input cosine, output ready);
endinterface

// ===== sv/scsu_mul64.sv =====
// Two-stage 64 by 64 bit unsigned multiplier built from four 32 by 32 partial products.
// Depends on nothing; used by the series terms and the back end.
`timescale 1ns / 1ps

module scsu_mul64 (
	input  logic         clk,
	input  logic         en,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] prod
);
	logic [63:0] p00_s1, p01_s1, p10_s1, p11_s1;
	logic [127:0] prod_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
			p01_s1 <= 64'(a[31:0]) * 64'(b[63:32]);
			p10_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
			p11_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
			prod_s2 <= (128'(p11_s1) << 64) + (128'(p01_s1) << 32)
				+ (128'(p10_s1) << 32) + 128'(p00_s1);
		end
	end

	assign prod = prod_s2;
endmodule

// ===== sv/scsu_term.sv =====
// One series term: multiplies by the squared angle, divides by a constant factorial step
// through a reciprocal with one correction, and adds the signed term. Uses scsu_pkg, scsu_mul64.
`timescale 1ns / 1ps

module scsu_term #(
	parameter int I = 1,
	parameter bit IS_SINE = 1'b1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  scsu_pkg::lane_t      lane_i,
	input  scsu_pkg::q58_t       t_i,
	output scsu_pkg::lane_t      lane_o,
	output scsu_pkg::q58_t       t_o
);
	localparam int DIV = IS_SINE ? (2 * I) * (2 * I + 1) : (2 * I - 1) * (2 * I);
	localparam int SH = $clog2(DIV + 1) - 1;
	localparam logic [127:0] RECIP_NUM = (128'd1 << (64 + SH)) - 128'd1;
	localparam logic [63:0] RECIP = 64'(RECIP_NUM / 128'(DIV));
	localparam logic [scsu_pkg::DIV_W-1:0] DIV_C = scsu_pkg::DIV_W'(DIV);

	logic [127:0] prod1, prod2;
	scsu_pkg::q58_t p_c, q0_c, r_c, t_nxt;
	scsu_pkg::q58_t p_s3, p_s4, p_s5, q0_s5, qd_s5, t_s6, acc_s6;
	scsu_pkg::lane_t lane_q [6];

	scsu_mul64 u_mul_sq (.clk(clk), .en(en), .a(t_i), .b(lane_i.m2), .prod(prod1));

	assign p_c = prod1[scsu_pkg::FRAC+63:scsu_pkg::FRAC];

	scsu_mul64 u_mul_rcp (.clk(clk), .en(en), .a(p_c), .b(RECIP), .prod(prod2));

	assign q0_c = 64'(prod2 >> (64 + SH));
	assign r_c = p_s5 - qd_s5;
	assign t_nxt = q0_s5 + 64'(r_c >= 64'(DIV_C));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) lane_q[k] <= '0;
		end else if (en) begin
			lane_q[0] <= lane_i;
			for (int k = 1; k < 6; k++) lane_q[k] <= lane_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= p_c;
			p_s4 <= p_s3;
			p_s5 <= p_s4;
			q0_s5 <= q0_c;
			qd_s5 <= 64'(q0_c * 64'(DIV_C));
			t_s6 <= t_nxt;
			acc_s6 <= lane_q[4].tneg ? lane_q[4].acc - t_nxt : lane_q[4].acc + t_nxt;
		end
	end

	assign lane_o = '{vld: lane_q[5].vld, tneg: ~lane_q[5].tneg, m2: lane_q[5].m2,
		acc: acc_s6};
	assign t_o = t_s6;
endmodule

// ===== sv/scsu_queue.sv =====
// Short word queue between the reduction front end and the series back end.
// Uses scsu_pkg.
`timescale 1ns / 1ps

module scsu_queue #(
	parameter int DEPTH = scsu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  scsu_pkg::qitem_t din,
	output logic             full,
	input  logic             pop,
	output scsu_pkg::qitem_t dout,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	scsu_pkg::qitem_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== sv/scsu_front.sv =====
// Front end: takes angle words and reduces them by the nearest multiple of two pi.
// Uses scsu_pkg and scsu_in_if; feeds scsu_queue.
`timescale 1ns / 1ps

module scsu_front (
	input  logic             clk,
	input  logic             arst_n,
	scsu_in_if.sink          angle_ch,
	input  logic             q_full,
	output logic             q_push,
	output scsu_pkg::qitem_t q_item
);
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic xneg_s1, xneg_s2, xneg_s3, xneg_s4, xneg_s5;
	logic [31:0] a_s1, a_s2, a_s3, a_s4;
	logic [63:0] prod_s2;
	logic [scsu_pkg::K_W-1:0] k_s3;
	logic [60:0] kc_s4;
	logic signed [63:0] d_s5;
	logic [63:0] dmag;

	assign en = !(v_s5 && q_full);
	assign angle_ch.ready = en;
	assign q_push = v_s5 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= angle_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xneg_s1 <= angle_ch.angle[31];
			a_s1 <= angle_ch.angle[31] ? 32'(32'd0 - angle_ch.angle) : angle_ch.angle;
			xneg_s2 <= xneg_s1;
			a_s2 <= a_s1;
			prod_s2 <= 64'(a_s1) * 64'(scsu_pkg::TWO_OVER_PI_Q32);
			xneg_s3 <= xneg_s2;
			a_s3 <= a_s2;
			k_s3 <= scsu_pkg::K_W'((prod_s2 + scsu_pkg::K_ROUND) >> scsu_pkg::K_SHIFT);
			xneg_s4 <= xneg_s3;
			a_s4 <= a_s3;
			kc_s4 <= 61'(61'(k_s3) * 61'(scsu_pkg::TWO_PI_Q44));
			xneg_s5 <= xneg_s4;
			d_s5 <= $signed({4'b0, a_s4, 28'b0}) - $signed({3'b0, kc_s4});
		end
	end

	assign dmag = d_s5[63] ? 64'(64'd0 - d_s5) : d_s5;
	assign q_item = '{mag: dmag << 14, neg: xneg_s5 ^ d_s5[63]};
endmodule

// ===== sv/scsu_back.sv =====
// Back end: squares the reduced angle, runs the sine and cosine term pipelines and rounds
// the sums to saturated Q2.30. Uses scsu_pkg, scsu_mul64, scsu_term and scsu_out_if.
`timescale 1ns / 1ps

module scsu_back #(
	parameter int SERIES_TERMS = scsu_pkg::SERIES_TERMS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  scsu_pkg::qitem_t q_item,
	output logic             q_pop,
	scsu_out_if.source       result_ch
);
	logic en;
	logic v_s1, v_s2, v_f1, v_out_q;
	logic rneg_s1, rneg_s2;
	scsu_pkg::q58_t m_s1, m_s2, m2_c;
	logic [127:0] m2_prod;
	scsu_pkg::lane_t sin_lane [SERIES_TERMS];
	scsu_pkg::lane_t cos_lane [SERIES_TERMS];
	scsu_pkg::q58_t sin_t [SERIES_TERMS];
	scsu_pkg::q58_t cos_t [SERIES_TERMS];
	logic sneg_f1, cneg_f1;
	scsu_pkg::q58_t smag_f1, cmag_f1;
	logic [31:0] sine_q, cosine_q;

	function automatic logic [31:0] to_q30(input logic neg, input scsu_pkg::q58_t mag);
		scsu_pkg::q58_t q;
		q = (mag + scsu_pkg::OUT_ROUND) >> (scsu_pkg::FRAC - 30);
		if (q > 64'(scsu_pkg::ONE_Q30)) begin
			q = 64'(scsu_pkg::ONE_Q30);
		end
		return neg ? 32'(64'd0 - q) : q[31:0];
	endfunction

	assign en = !(v_out_q && !result_ch.ready);
	assign q_pop = en && !q_empty;

	scsu_mul64 u_mul_m2 (.clk(clk), .en(en), .a(q_item.mag), .b(q_item.mag), .prod(m2_prod));

	assign m2_c = m2_prod[scsu_pkg::FRAC+63:scsu_pkg::FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_f1 <= 1'b0;
			v_out_q <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_f1 <= sin_lane[SERIES_TERMS-1].vld;
			v_out_q <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= q_item.mag;
			rneg_s1 <= q_item.neg;
			m_s2 <= m_s1;
			rneg_s2 <= rneg_s1;
			sneg_f1 <= sin_lane[SERIES_TERMS-1].acc[63];
			smag_f1 <= sin_lane[SERIES_TERMS-1].acc[63]
				? 64'd0 - sin_lane[SERIES_TERMS-1].acc : sin_lane[SERIES_TERMS-1].acc;
			cneg_f1 <= cos_lane[SERIES_TERMS-1].acc[63];
			cmag_f1 <= cos_lane[SERIES_TERMS-1].acc[63]
				? 64'd0 - cos_lane[SERIES_TERMS-1].acc : cos_lane[SERIES_TERMS-1].acc;
			sine_q <= to_q30(sneg_f1, smag_f1);
			cosine_q <= to_q30(cneg_f1, cmag_f1);
		end
	end

	assign sin_lane[0] = '{vld: v_s2, tneg: ~rneg_s2, m2: m2_c,
		acc: rneg_s2 ? 64'd0 - m_s2 : m_s2};
	assign sin_t[0] = m_s2;
	assign cos_lane[0] = '{vld: v_s2, tneg: 1'b1, m2: m2_c, acc: scsu_pkg::ONE_Q58};
	assign cos_t[0] = scsu_pkg::ONE_Q58;

	for (genvar gi = 1; gi < SERIES_TERMS; gi++) begin : g_term
		scsu_term #(.I(gi), .IS_SINE(1'b1)) u_sin (
			.clk(clk), .arst_n(arst_n), .en(en),
			.lane_i(sin_lane[gi-1]), .t_i(sin_t[gi-1]),
			.lane_o(sin_lane[gi]), .t_o(sin_t[gi])
		);
		scsu_term #(.I(gi), .IS_SINE(1'b0)) u_cos (
			.clk(clk), .arst_n(arst_n), .en(en),
			.lane_i(cos_lane[gi-1]), .t_i(cos_t[gi-1]),
			.lane_o(cos_lane[gi]), .t_o(cos_t[gi])
		);
	end

	assign result_ch.valid = v_out_q;
	assign result_ch.sine = sine_q;
	assign result_ch.cosine = cosine_q;
endmodule

// ===== sv/sine_cosine_series_unit.sv =====
// Path: an accepted angle word passes the front end and may wait in the queue before
// the back end turns it into its result word.
// Throughput: one word per cycle; each scsu_term is a six-stage pipelined multiply and
// constant divide, so a new angle enters each cycle while the result side takes words.
// Reset: arst_n clears all valid flags and queue pointers at once; no clearing pass.
`timescale 1ns / 1ps
`include "sine_cosine_series_unit_macros.svh"

module sine_cosine_series_unit #(
	parameter int SERIES_TERMS = scsu_pkg::SERIES_TERMS_DEF,
	parameter int QUEUE_DEPTH = scsu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	scsu_in_if.sink     angle_ch,
	scsu_out_if.source  result_ch
);
	logic q_push, q_full, q_pop, q_empty;
	scsu_pkg::qitem_t q_din, q_dout;

	scsu_front u_front (
		.clk(clk), .arst_n(arst_n), .angle_ch(angle_ch),
		.q_full(q_full), .q_push(q_push), .q_item(q_din)
	);

	scsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .din(q_din), .full(q_full),
		.pop(q_pop), .dout(q_dout), .empty(q_empty)
	);

	scsu_back #(.SERIES_TERMS(SERIES_TERMS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_item(q_dout),
		.q_pop(q_pop), .result_ch(result_ch)
	);

	`SCSU_CHECK(a_push_room, clk, arst_n, q_push, !q_full, "queue written while full")
	`SCSU_CHECK(a_pop_data, clk, arst_n, q_pop, !q_empty, "queue read while empty")
	`SCSU_CHECK_NEXT(a_push_fill, clk, arst_n, q_push, !q_empty, "queue lost a word")
	`SCSU_CHECK(a_sine_range, clk, arst_n, result_ch.valid, (result_ch.sine >= -32'sd1073741824) && (result_ch.sine <= 32'sd1073741824), "sine beyond one")
	`SCSU_CHECK(a_cosine_range, clk, arst_n, result_ch.valid, (result_ch.cosine >= -32'sd1073741824) && (result_ch.cosine <= 32'sd1073741824), "cosine beyond one")
endmodule
